@@ rtl/mwo_pkg.sv @@
// Shared types, constants and sine table builder for the multi-waveform oscillator.
package mwo_pkg;

    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned SAMPLE_BITS_DEF     = 16;
    localparam int unsigned TABLE_ADDR_BITS_DEF = 8;

    // APB register window: four 32-bit registers at byte addresses 0, 4, 8, 12
    localparam int unsigned CFG_ADDR_BITS = 4;
    localparam int unsigned CFG_DATA_BITS = 32;

    localparam logic [15:0] AMP_RESET = 16'd32768;

    // pi/2 in unsigned Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    typedef enum logic [1:0] {
        REG_PHASE_STEP   = 2'd0,
        REG_WAVE_SELECT  = 2'd1,
        REG_AMPLITUDE    = 2'd2,
        REG_SAMPLE_COUNT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] phase_step;
        t_wave       wave_select;
        logic [15:0] amplitude;
        logic [31:0] sample_count;
    } t_cfg;

    // Quarter-wave magnitude for entry k of a (2^tb + 1)-entry table, Q1.(sb-1).
    // Seven-term Taylor series in Q2.30, each product truncated.
    function automatic logic [31:0] sine_entry(input int unsigned k, input int unsigned tb,
                                               input int unsigned sb);
        logic [63:0] ang;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] full;
        ang  = (HALF_PI_Q30 * 64'(k) + ((64'd1 << tb) >> 1)) >> tb;
        x2   = (ang * ang) >> 30;
        term = ang;
        pos  = ang;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156;
        pos  = pos + term;
        s    = (pos > neg) ? (pos - neg) : 64'd0;
        v    = (s + (64'd1 << (30 - sb))) >> (31 - sb);
        full = 64'd1 << (sb - 1);
        if (v > full) begin
            v = full;
        end
        return v[31:0];
    endfunction

endpackage

@@ rtl/mwo_tick_if.sv @@
// Tick channel: valid/ready handshake carrying the restart flag.
interface mwo_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

@@ rtl/mwo_smp_if.sv @@
// Sample channel: valid/ready handshake carrying one waveform sample and the last flag.
interface mwo_smp_if #(
    parameter int unsigned SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ rtl/multi_waveform_oscillator_top.sv @@
// Top level of the multi-waveform DDS oscillator: register file and three-stage sample pipeline.
//
// Usage
//   i_tick (sink): one transfer per sample tick; restart=1 clears the phase and the
//   sample counter before that tick's sample is formed.
//   o_smp (source): one transfer per emitted sample, sample in two's complement
//   Q1.(SAMPLE_BITS-1), last=1 on the final sample of the run. A tick taken after
//   sample_count samples (or with sample_count 0) yields no sample.
//   APB port: phase_step at 0x0, wave_select at 0x4, amplitude at 0x8,
//   sample_count at 0xC; pready is tied high. Write only while the block is idle.
// Timing
//   Pipeline: a sample is presented on o_smp once its tick has passed the phase
//   register, the waveform register and the output register.
//   Throughput: one tick per cycle unless stalled, set by the phase add and run counter.
// Reset
//   Synchronous, active low: phase and counter clear, registers take their reset values
//   (sine, full-scale amplitude, zero step and count), the pipeline empties.
// Stall
//   Each stage loads when empty or when the stage behind it drains, so a stalled
//   receiver backs up at most three samples before i_tick.ready drops.
module multi_waveform_oscillator_top #(
    parameter int unsigned PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = mwo_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mwo_tick_if.sink                          i_tick,
    mwo_smp_if.source                         o_smp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mwo_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [mwo_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [mwo_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    mwo_pkg::t_cfg         w_cfg;

    logic                  w_s1_valid;
    logic [PHASE_BITS-1:0] w_s1_phase;
    logic                  w_s1_last;
    logic                  w_s1_ready;

    logic                  w_s2_valid;
    logic [SAMPLE_BITS:0]  w_s2_w;
    logic                  w_s2_last;
    logic                  w_s2_ready;

    assign pready = 1'b1;

    mwo_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // Stage 1: restart, run check, phase advance; register the tick's phase.
    mwo_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_tick_valid (i_tick.valid),
        .i_restart    (i_tick.restart),
        .o_tick_ready (i_tick.ready),
        .o_s1_valid   (w_s1_valid),
        .o_s1_phase   (w_s1_phase),
        .o_s1_last    (w_s1_last),
        .i_s1_ready   (w_s1_ready)
    );

    // Stage 2: form the full-scale waveform value.
    mwo_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_wave (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wave     (w_cfg.wave_select),
        .i_s1_valid (w_s1_valid),
        .i_s1_phase (w_s1_phase),
        .i_s1_last  (w_s1_last),
        .o_s1_ready (w_s1_ready),
        .o_s2_valid (w_s2_valid),
        .o_s2_w     (w_s2_w),
        .o_s2_last  (w_s2_last),
        .i_s2_ready (w_s2_ready)
    );

    // Stage 3: scale by amplitude, saturate, hold for the receiver.
    mwo_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_amp      (w_cfg.amplitude),
        .i_s2_valid (w_s2_valid),
        .i_s2_w     (w_s2_w),
        .i_s2_last  (w_s2_last),
        .o_s2_ready (w_s2_ready),
        .o_valid    (o_smp.valid),
        .o_sample   (o_smp.sample),
        .o_last     (o_smp.last),
        .i_ready    (o_smp.ready)
    );

    // A tick taken with an empty run must not reach the pipeline.
    a_no_sample_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.valid && i_tick.ready && (w_cfg.sample_count == 32'd0)) |=> !w_s1_valid)
        else $error("sample issued with sample_count zero");

    // Hold the registered phase while the waveform stage is blocked.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_valid && !w_s1_ready) |=> (w_s1_valid && $stable(w_s1_phase)
                                         && $stable(w_s1_last)))
        else $error("stage 1 dropped or changed a stalled sample");

    // Hold the waveform value while the output register is blocked.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_valid && !w_s2_ready) |=> (w_s2_valid && $stable(w_s2_w)))
        else $error("stage 2 dropped or changed a stalled sample");

endmodule

@@ rtl/mwo_regs.sv @@
// APB configuration register file.
module mwo_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [mwo_pkg::CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [mwo_pkg::CFG_DATA_BITS-1:0] i_pwdata,
    output logic [mwo_pkg::CFG_DATA_BITS-1:0] o_prdata,
    output mwo_pkg::t_cfg                     o_cfg
);

    mwo_pkg::t_cfg    r_cfg;
    mwo_pkg::t_reg_idx w_idx;

    assign w_idx = mwo_pkg::t_reg_idx'(i_paddr[mwo_pkg::CFG_ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= '0;
            r_cfg.wave_select  <= mwo_pkg::WAVE_SINE;
            r_cfg.amplitude    <= mwo_pkg::AMP_RESET;
            r_cfg.sample_count <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (w_idx)
                mwo_pkg::REG_PHASE_STEP:   r_cfg.phase_step   <= i_pwdata;
                mwo_pkg::REG_WAVE_SELECT:  r_cfg.wave_select  <= mwo_pkg::t_wave'(i_pwdata[1:0]);
                mwo_pkg::REG_AMPLITUDE:    r_cfg.amplitude    <= i_pwdata[15:0];
                mwo_pkg::REG_SAMPLE_COUNT: r_cfg.sample_count <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            mwo_pkg::REG_PHASE_STEP:   o_prdata = r_cfg.phase_step;
            mwo_pkg::REG_WAVE_SELECT:  o_prdata = {30'd0, r_cfg.wave_select};
            mwo_pkg::REG_AMPLITUDE:    o_prdata = {16'd0, r_cfg.amplitude};
            mwo_pkg::REG_SAMPLE_COUNT: o_prdata = r_cfg.sample_count;
            default:                   o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/mwo_phase.sv @@
// Phase accumulator and run counter; registers the phase of each emitted tick.
module mwo_phase #(
    parameter int unsigned PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mwo_pkg::t_cfg         i_cfg,
    input  logic                  i_tick_valid,
    input  logic                  i_restart,
    output logic                  o_tick_ready,
    output logic                  o_s1_valid,
    output logic [PHASE_BITS-1:0] o_s1_phase,
    output logic                  o_s1_last,
    input  logic                  i_s1_ready
);

    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS-1:0] n_phase_acc;
    logic [31:0]           r_count;
    logic [31:0]           n_count;
    logic                  r_s1_valid;
    logic [PHASE_BITS-1:0] r_s1_phase;
    logic                  r_s1_last;

    logic                  w_load;
    logic                  w_acc;
    logic [PHASE_BITS-1:0] w_ph;
    logic [PHASE_BITS-1:0] w_step;
    logic [31:0]           w_cnt;
    logic [32:0]           w_cnt_inc;
    logic                  w_active;
    logic                  w_last;

    assign w_load    = !r_s1_valid || i_s1_ready;
    assign w_acc     = i_tick_valid && w_load;
    assign w_ph      = i_restart ? '0 : r_phase_acc;
    assign w_cnt     = i_restart ? '0 : r_count;
    assign w_step    = PHASE_BITS'(i_cfg.phase_step);
    assign w_cnt_inc = {1'b0, w_cnt} + 33'd1;
    assign w_active  = w_cnt < i_cfg.sample_count;
    assign w_last    = w_cnt_inc == {1'b0, i_cfg.sample_count};

    // Advance only when a sample goes out; restart clears even when the run is over.
    assign n_phase_acc = w_active ? (w_ph + w_step) : w_ph;
    assign n_count     = w_active ? w_cnt_inc[31:0] : w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_phase_acc <= n_phase_acc;
                r_count     <= n_count;
            end
            if (w_load) begin
                r_s1_valid <= w_acc && w_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_phase <= w_ph;
            r_s1_last  <= w_last;
        end
    end

    assign o_tick_ready = w_load;
    assign o_s1_valid   = r_s1_valid;
    assign o_s1_phase   = r_s1_phase;
    assign o_s1_last    = r_s1_last;

endmodule

@@ rtl/mwo_wave.sv @@
// Raw waveform stage: sine table lookup, square, sawtooth and triangle at full scale.
module mwo_wave #(
    parameter int unsigned PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = mwo_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mwo_pkg::t_wave         i_wave,
    input  logic                   i_s1_valid,
    input  logic [PHASE_BITS-1:0]  i_s1_phase,
    input  logic                   i_s1_last,
    output logic                   o_s1_ready,
    output logic                   o_s2_valid,
    output logic [SAMPLE_BITS:0]   o_s2_w,
    output logic                   o_s2_last,
    input  logic                   i_s2_ready
);

    localparam int unsigned TAB_N = 1 << TABLE_ADDR_BITS;
    localparam logic [TABLE_ADDR_BITS:0] TAB_LAST = (TABLE_ADDR_BITS + 1)'(TAB_N);
    localparam logic [SAMPLE_BITS:0] FS = (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1);

    logic [SAMPLE_BITS-1:0] w_qtab [TAB_N+1];

    for (genvar k = 0; k <= TAB_N; k++) begin : g_qtab
        assign w_qtab[k] = SAMPLE_BITS'(mwo_pkg::sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
    end

    logic                              r_s2_valid;
    logic [SAMPLE_BITS:0]              r_s2_w;
    logic                              r_s2_last;

    logic                              w_load;
    logic [PHASE_BITS+SAMPLE_BITS-1:0] w_ext;
    logic [SAMPLE_BITS-1:0]            w_u;
    logic [1:0]                        w_quad;
    logic [TABLE_ADDR_BITS-1:0]        w_idx;
    logic [TABLE_ADDR_BITS:0]          w_addr;
    logic [SAMPLE_BITS-1:0]            w_mag;
    logic [SAMPLE_BITS-1:0]            w_dist;
    logic [SAMPLE_BITS:0]              w_sine;
    logic [SAMPLE_BITS:0]              w_square;
    logic [SAMPLE_BITS:0]              w_saw;
    logic [SAMPLE_BITS:0]              w_tri;
    logic [SAMPLE_BITS:0]              n_s2_w;

    // Top SAMPLE_BITS of the phase, zero padded when the phase is narrower.
    assign w_ext  = {i_s1_phase, {SAMPLE_BITS{1'b0}}};
    assign w_u    = w_ext[PHASE_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign w_quad = i_s1_phase[PHASE_BITS-1 -: 2];
    assign w_idx  = i_s1_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    // Mirror the index in odd quadrants, negate in the lower half-turn.
    assign w_addr = w_quad[0] ? (TAB_LAST - {1'b0, w_idx}) : {1'b0, w_idx};
    assign w_mag  = w_qtab[w_addr];
    assign w_sine = w_quad[1] ? (-{1'b0, w_mag}) : {1'b0, w_mag};

    assign w_square = ((|i_s1_phase) && !i_s1_phase[PHASE_BITS-1]) ? FS : -FS;
    assign w_saw    = {1'b0, w_u} - FS;

    // Distance to the nearest whole turn, then 2d - FS.
    assign w_dist = w_u[SAMPLE_BITS-1] ? (-w_u) : w_u;
    assign w_tri  = {w_dist, 1'b0} - FS;

    always_comb begin
        case (i_wave)
            mwo_pkg::WAVE_SINE:     n_s2_w = w_sine;
            mwo_pkg::WAVE_SQUARE:   n_s2_w = w_square;
            mwo_pkg::WAVE_SAW:      n_s2_w = w_saw;
            mwo_pkg::WAVE_TRIANGLE: n_s2_w = w_tri;
            default:                n_s2_w = w_sine;
        endcase
    end

    assign w_load = !r_s2_valid || i_s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_load) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s2_w    <= n_s2_w;
            r_s2_last <= i_s1_last;
        end
    end

    assign o_s1_ready = w_load;
    assign o_s2_valid = r_s2_valid;
    assign o_s2_w     = r_s2_w;
    assign o_s2_last  = r_s2_last;

endmodule

@@ rtl/mwo_scale.sv @@
// Amplitude scaling with rounding and saturation; holds the output register.
module mwo_scale #(
    parameter int unsigned SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [15:0]            i_amp,
    input  logic                   i_s2_valid,
    input  logic [SAMPLE_BITS:0]   i_s2_w,
    input  logic                   i_s2_last,
    output logic                   o_s2_ready,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_last,
    input  logic                   i_ready
);

    localparam logic [SAMPLE_BITS+1:0] FS = (SAMPLE_BITS + 2)'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS+16:0] RND = (SAMPLE_BITS + 17)'(1) << 14;

    logic                    r_valid;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic                    r_last;

    logic                    w_load;
    logic                    w_neg;
    logic [SAMPLE_BITS:0]    w_abs;
    logic [SAMPLE_BITS+15:0] w_prod;
    logic [SAMPLE_BITS+16:0] w_rnd;
    logic [SAMPLE_BITS+1:0]  w_r;
    logic                    w_over;
    logic [SAMPLE_BITS+1:0]  w_res;

    assign w_neg  = i_s2_w[SAMPLE_BITS];
    assign w_abs  = w_neg ? (-i_s2_w) : i_s2_w;
    assign w_prod = w_abs[SAMPLE_BITS-1:0] * i_amp;
    // Round half away from zero on the magnitude.
    assign w_rnd  = {1'b0, w_prod} + RND;
    assign w_r    = w_rnd[SAMPLE_BITS+16:15];
    assign w_over = w_r >= FS;

    always_comb begin
        if (w_neg) begin
            w_res = w_over ? (-FS) : (-w_r);
        end else begin
            w_res = w_over ? (FS - (SAMPLE_BITS + 2)'(1)) : w_r;
        end
    end

    assign w_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sample <= w_res[SAMPLE_BITS-1:0];
            r_last   <= i_s2_last;
        end
    end

    assign o_s2_ready = w_load;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;
    assign o_last     = r_last;

endmodule

@@ sim/mwo_sample_checker.sv @@
// Sample checker: tracks oscillator settings and ticks, predicts each sample and compares it.
module mwo_sample_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick_valid,
    input  logic        i_tick_ready,
    input  logic        i_tick_restart,
    input  logic        i_smp_valid,
    input  logic        i_smp_ready,
    input  logic [15:0] i_smp_sample,
    input  logic        i_smp_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TAB_BITS   = 8;
    localparam int unsigned TAB_N      = 1 << TAB_BITS;
    localparam longint      FULL_SCALE = 32768;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_smp_exp;

    t_smp_exp    expected_samples[$];
    logic [15:0] quarter_mag[0:TAB_N];

    // Oscillator settings and run state as the block should hold them
    logic [31:0]    osc_step;
    mwo_pkg::t_wave osc_wave;
    logic [15:0]    osc_amp;
    logic [31:0]    osc_count;
    logic [31:0]    osc_phase;
    logic [31:0]    osc_emitted;

    // Quarter-wave magnitude: Taylor series of sin in Q2.30, rounded to Q1.15
    function automatic logic [15:0] sine_mag(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] v;
        x    = (PI_HALF_Q30 * 64'(k) + 64'(TAB_N >> 1)) >> TAB_BITS;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        v = (s + 64'd16384) >> 15;
        if (v > 64'(FULL_SCALE)) begin
            v = 64'(FULL_SCALE);
        end
        return v[15:0];
    endfunction

    function automatic longint wave_value(input logic [31:0] ph, input mwo_pkg::t_wave w);
        longint m;
        longint u;
        longint d;
        longint res;
        u = longint'({48'd0, ph[31:16]});
        case (w)
            mwo_pkg::WAVE_SINE: begin
                if (ph[30]) begin
                    m = longint'({48'd0, quarter_mag[TAB_N - int'(ph[29:22])]});
                end else begin
                    m = longint'({48'd0, quarter_mag[int'(ph[29:22])]});
                end
                res = ph[31] ? -m : m;
            end
            mwo_pkg::WAVE_SQUARE: begin
                res = (ph != 32'd0 && ph < 32'h8000_0000) ? FULL_SCALE : -FULL_SCALE;
            end
            mwo_pkg::WAVE_SAW: begin
                res = u - FULL_SCALE;
            end
            default: begin
                d   = (u < FULL_SCALE) ? u : 65536 - u;
                res = 2 * d - FULL_SCALE;
            end
        endcase
        return res;
    endfunction

    function automatic logic [15:0] scaled_sample(input longint w, input logic [15:0] amp);
        longint mag;
        longint r;
        mag = ((w < 0) ? -w : w) * longint'({48'd0, amp});
        r   = (mag + 16384) >>> 15;
        if (w < 0) begin
            r = -r;
        end
        if (r > FULL_SCALE - 1) begin
            r = FULL_SCALE - 1;
        end
        if (r < -FULL_SCALE) begin
            r = -FULL_SCALE;
        end
        return r[15:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t ns] sample check: %s", $time, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int k = 0; k <= TAB_N; k++) begin
            quarter_mag[k] = sine_mag(k);
        end
    end

    always @(posedge i_clk) begin
        t_smp_exp          want;
        mwo_pkg::t_reg_idx ridx;
        if (!i_rst_n) begin
            osc_step    = 32'd0;
            osc_wave    = mwo_pkg::WAVE_SINE;
            osc_amp     = mwo_pkg::AMP_RESET;
            osc_count   = 32'd0;
            osc_phase   = 32'd0;
            osc_emitted = 32'd0;
            expected_samples.delete();
        end else begin
            if (i_smp_valid && i_smp_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %h last %b",
                                              i_smp_sample, i_smp_last));
                end else begin
                    want = expected_samples.pop_front();
                    if (i_smp_sample !== want.sample) begin
                        report_mismatch($sformatf("sample %h, predicted %h",
                                                  i_smp_sample, want.sample));
                    end
                    if (i_smp_last !== want.last) begin
                        report_mismatch($sformatf("last %b, predicted %b",
                                                  i_smp_last, want.last));
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                ridx = mwo_pkg::t_reg_idx'(i_paddr[3:2]);
                case (ridx)
                    mwo_pkg::REG_PHASE_STEP:   osc_step  = i_pwdata;
                    mwo_pkg::REG_WAVE_SELECT:  osc_wave  = mwo_pkg::t_wave'(i_pwdata[1:0]);
                    mwo_pkg::REG_AMPLITUDE:    osc_amp   = i_pwdata[15:0];
                    mwo_pkg::REG_SAMPLE_COUNT: osc_count = i_pwdata;
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                if (i_tick_restart) begin
                    osc_phase   = 32'd0;
                    osc_emitted = 32'd0;
                end
                if (osc_emitted < osc_count) begin
                    want.sample = scaled_sample(wave_value(osc_phase, osc_wave), osc_amp);
                    want.last   = ({1'b0, osc_emitted} + 33'd1 == {1'b0, osc_count});
                    expected_samples.push_back(want);
                    osc_emitted = osc_emitted + 32'd1;
                    osc_phase   = osc_phase + osc_step;
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top: drives ticks and register writes into the oscillator and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling on the length of the run, in clock cycles
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1100;
    localparam int DRAIN_SETTLE = 4;
    localparam int LONG_HOLD    = 300;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int cycles;
    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int items_sent;

    mwo_tick_if tick_if ();
    mwo_smp_if #(.SAMPLE_BITS(16)) smp_if ();

    multi_waveform_oscillator_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if),
        .o_smp   (smp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mwo_sample_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_tick_valid   (tick_if.valid),
        .i_tick_ready   (tick_if.ready),
        .i_tick_restart (tick_if.restart),
        .i_smp_valid    (smp_if.valid),
        .i_smp_ready    (smp_if.ready),
        .i_smp_sample   (smp_if.sample),
        .i_smp_last     (smp_if.last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: count cycles and abort the run once the ceiling is hit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("watchdog: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sample receiver: drop ready at random per the stall rate, or hold it low
    // for a whole hold-off stretch when one is requested
    initial begin
        smp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                smp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                smp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one tick and hold it until the transfer; entered and left at a falling edge.
    // Idle cycles go in front of the tick, so gaps land anywhere in the stream.
    task automatic send_tick(input logic restart_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(negedge clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.restart <= restart_flag;
        do begin
            @(posedge clk);
        end while (!tick_if.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the tick channel quiet until every predicted sample has been seen,
    // then let the pipeline settle before anything else happens
    task automatic wait_drained();
        tick_if.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_SETTLE) @(negedge clk);
    endtask

    // Two-phase APB write: setup, then access until pready, then back to idle
    task automatic cfg_write(input mwo_pkg::t_reg_idx ridx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do begin
            @(posedge clk);
        end while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drain, then load a full oscillator setting
    task automatic apply_setting(input logic [31:0] step, input mwo_pkg::t_wave wave,
                                 input logic [15:0] amp, input logic [31:0] count);
        wait_drained();
        cfg_write(mwo_pkg::REG_PHASE_STEP, step);
        cfg_write(mwo_pkg::REG_WAVE_SELECT, {30'd0, wave});
        cfg_write(mwo_pkg::REG_AMPLITUDE, {16'd0, amp});
        cfg_write(mwo_pkg::REG_SAMPLE_COUNT, count);
    endtask

    initial begin
        logic [31:0]    step;
        logic [15:0]    amp;
        logic [31:0]    count;
        mwo_pkg::t_wave wave;
        int             n_items;
        int             idx;
        int             pat;

        // Drive every input from time zero and hold the block in reset
        rst_n           = 1'b0;
        tick_if.valid   = 1'b0;
        tick_if.restart = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_left       = 0;
        items_sent      = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: each waveform stepped by an eighth turn, so the samples land on
        // zero phase, the quadrant points and the half turn. Full scale, the saturating
        // gain above full scale and zero gain all show up. The sixth tick of each run
        // finds the run finished and must yield nothing.
        for (int w = 0; w < 4; w++) begin
            case (w)
                0:       amp = 16'd32768;
                1:       amp = 16'hFFFF;
                2:       amp = 16'd0;
                default: amp = 16'd32768;
            endcase
            apply_setting(32'h2000_0000, mwo_pkg::t_wave'(w), amp, 32'd5);
            send_tick(1'b1);
            repeat (5) send_tick(1'b0);
        end
        // A zero sample count never emits, even right after restart
        apply_setting(32'h2000_0000, mwo_pkg::WAVE_SINE, 16'd32768, 32'd0);
        send_tick(1'b1);

        // Random settings, each with a short burst of ticks. The idle pattern rotates:
        // none, sender gaps, receiver stalls, both.
        idx = 0;
        while (items_sent < ITEM_TARGET) begin
            pat = idx % 4;
            case ($urandom_range(9))
                0:       step = 32'd0;
                1:       step = 32'hFFFF_FFFF;
                2, 3:    step = $urandom;
                default: step = $urandom >> $urandom_range(8);
            endcase
            wave = mwo_pkg::t_wave'($urandom_range(3));
            case ($urandom_range(7))
                0:       amp = 16'd0;
                1:       amp = 16'd32768;
                2:       amp = 16'hFFFF;
                default: amp = 16'($urandom_range(65535));
            endcase
            case ($urandom_range(19))
                0:       count = 32'd0;
                1:       count = 32'hFFFF_FFFF;
                2, 3:    count = $urandom;
                default: count = $urandom_range(1, 40);
            endcase
            n_items = $urandom_range(10, 45);
            // One setting keeps the run open and the receiver shut, so the
            // pipeline fills and the tick channel backs up
            if (idx == 6) begin
                count   = 32'hFFFF_FFFF;
                n_items = 40;
            end
            apply_setting(step, wave, amp, count);
            case (pat)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default: begin
                    send_idle_pct = 19;
                    stall_pct     = 19;
                end
            endcase
            if (idx == 6) begin
                hold_left = LONG_HOLD;
            end
            // Mostly start a fresh run; otherwise carry the old count and phase over,
            // which ends the run at once when the new count is not above it
            send_tick($urandom_range(9) < 7);
            for (int i = 1; i < n_items; i++) begin
                // Once, stop offering ticks halfway until the output has caught up
                if (idx == 10 && i == n_items / 2) begin
                    wait_drained();
                end
                send_tick($urandom_range(19) == 0);
            end
            idx++;
        end

        // Flush the pipeline and give the verdict
        wait_drained();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ multi_waveform_oscillator_top.f @@
rtl/mwo_pkg.sv
rtl/mwo_tick_if.sv
rtl/mwo_smp_if.sv
rtl/mwo_regs.sv
rtl/mwo_phase.sv
rtl/mwo_wave.sv
rtl/mwo_scale.sv
rtl/multi_waveform_oscillator_top.sv
sim/mwo_sample_checker.sv
sim/tb_top.sv
